### design/esp_pkg.sv
// ----------------------------------------------------------------------------
// esp_pkg
// Shared types and byte constants for the emoji space padder.
// ----------------------------------------------------------------------------
package esp_pkg;

    localparam int unsigned MAX_OUT = 5;

    localparam logic [7:0] C_SPACE     = 8'h20;
    localparam logic [7:0] C_LEAD4     = 8'hF0;
    localparam logic [7:0] C_PLANE     = 8'h9F;
    localparam logic [7:0] C_LEAD3     = 8'hE2;
    localparam logic [7:0] C_SYM_LO    = 8'h98;
    localparam logic [7:0] C_SYM_HI    = 8'h9E;
    localparam logic [7:0] C_CONT_MASK = 8'hC0;
    localparam logic [7:0] C_CONT      = 8'h80;
    localparam logic [7:0] C_VS_LEAD   = 8'hEF;
    localparam logic [7:0] C_VS_MID    = 8'hB8;
    localparam logic [7:0] C_VS_TEXT   = 8'h8E;
    localparam logic [7:0] C_VS_EMOJI  = 8'h8F;

    typedef enum logic [8:0] {
        PH_IDLE      = 9'b000000001,
        PH_F0        = 9'b000000010,
        PH_F0_9F     = 9'b000000100,
        PH_F0_9F_C   = 9'b000001000,
        PH_E2        = 9'b000010000,
        PH_E2_X      = 9'b000100000,
        PH_RUN       = 9'b001000000,
        PH_RUN_EF    = 9'b010000000,
        PH_RUN_EF_B8 = 9'b100000000
    } t_phase;

    typedef struct packed {
        logic [MAX_OUT-1:0][7:0] bytes;
        logic [2:0]              cnt;
        logic                    last;
    } t_res;

endpackage

### design/esp_scan.sv
// ----------------------------------------------------------------------------
// esp_scan
// Request register, match state and the per-byte rewrite logic.
// ----------------------------------------------------------------------------
module esp_scan
    import esp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output logic       o_stall,
    input  logic       i_free,
    output logic       o_load,
    output t_res       o_res
);

    typedef struct packed {
        t_phase                  phase;
        logic [2:0][7:0]         held;
        logic                    wrote;
        logic                    space;
        logic [MAX_OUT-1:0][7:0] bytes;
        logic [2:0]              cnt;
    } t_st;

    logic            r_in_valid;
    logic [7:0]      r_in_byte;
    logic            r_in_last;
    t_phase          r_phase;
    logic [2:0][7:0] r_held;
    logic            r_wrote;
    logic            r_space;

    logic            in_acc;
    logic            proc;
    t_st             s;

    function automatic t_st f_emit(t_st st, logic [7:0] b);
        t_st r;
        r = st;
        if (r.cnt < 3'(MAX_OUT)) begin
            r.bytes[r.cnt] = b;
            r.cnt = r.cnt + 3'd1;
        end
        r.wrote = 1'b1;
        r.space = (b == C_SPACE);
        return r;
    endfunction

    function automatic t_st f_held(t_st st, logic [1:0] n);
        t_st r;
        r = st;
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < n) begin
                r = f_emit(r, r.held[i]);
            end
        end
        return r;
    endfunction

    function automatic t_st f_idle(t_st st, logic [7:0] b);
        t_st r;
        r = st;
        if (b == C_LEAD4) begin
            r.held[0] = b;
            r.phase = PH_F0;
        end else if (b == C_LEAD3) begin
            r.held[0] = b;
            r.phase = PH_E2;
        end else begin
            r.phase = PH_IDLE;
            r = f_emit(r, b);
        end
        return r;
    endfunction

    function automatic t_st f_fail(t_st st, logic [1:0] n, logic [7:0] b);
        t_st r;
        r = st;
        r.phase = PH_IDLE;
        r = f_held(r, n);
        r = f_idle(r, b);
        return r;
    endfunction

    function automatic t_st f_pre(t_st st);
        t_st r;
        r = st;
        if (r.wrote && !r.space) begin
            r = f_emit(r, C_SPACE);
        end
        return r;
    endfunction

    function automatic t_st f_flush(t_st st);
        t_st r;
        r = st;
        case (r.phase)
            PH_F0, PH_E2: begin
                r = f_held(r, 2'd1);
            end
            PH_F0_9F, PH_E2_X: begin
                r = f_held(r, 2'd2);
            end
            PH_F0_9F_C: begin
                r = f_held(r, 2'd3);
            end
            PH_RUN_EF: begin
                r = f_emit(r, C_SPACE);
                r = f_held(r, 2'd1);
            end
            PH_RUN_EF_B8: begin
                r = f_emit(r, C_SPACE);
                r = f_held(r, 2'd2);
            end
            default: begin
            end
        endcase
        r.phase = PH_IDLE;
        r.wrote = 1'b0;
        r.space = 1'b0;
        return r;
    endfunction

    function automatic logic f_cont(logic [7:0] b);
        return (b & C_CONT_MASK) == C_CONT;
    endfunction

    assign proc    = r_in_valid && i_free;
    assign o_stall = r_in_valid && !i_free;
    assign in_acc  = i_valid && !o_stall;

    always_comb begin
        s.phase = r_phase;
        s.held  = r_held;
        s.wrote = r_wrote;
        s.space = r_space;
        s.bytes = '0;
        s.cnt   = '0;
        case (r_phase)
            PH_F0: begin
                if (r_in_byte == C_PLANE) begin
                    s.held[1] = r_in_byte;
                    s.phase = PH_F0_9F;
                end else begin
                    s = f_fail(s, 2'd1, r_in_byte);
                end
            end
            PH_F0_9F: begin
                if (f_cont(r_in_byte)) begin
                    s.held[2] = r_in_byte;
                    s.phase = PH_F0_9F_C;
                end else begin
                    s = f_fail(s, 2'd2, r_in_byte);
                end
            end
            PH_F0_9F_C: begin
                if (f_cont(r_in_byte)) begin
                    s = f_pre(s);
                    s = f_held(s, 2'd3);
                    s = f_emit(s, r_in_byte);
                    s.phase = PH_RUN;
                end else begin
                    s = f_fail(s, 2'd3, r_in_byte);
                end
            end
            PH_E2: begin
                if (r_in_byte inside {[C_SYM_LO:C_SYM_HI]}) begin
                    s.held[1] = r_in_byte;
                    s.phase = PH_E2_X;
                end else begin
                    s = f_fail(s, 2'd1, r_in_byte);
                end
            end
            PH_E2_X: begin
                if (f_cont(r_in_byte)) begin
                    s = f_pre(s);
                    s = f_held(s, 2'd2);
                    s = f_emit(s, r_in_byte);
                    s.phase = PH_RUN;
                end else begin
                    s = f_fail(s, 2'd2, r_in_byte);
                end
            end
            PH_RUN: begin
                if (r_in_byte == C_VS_LEAD) begin
                    s.held[0] = r_in_byte;
                    s.phase = PH_RUN_EF;
                end else begin
                    if (r_in_byte != C_SPACE) begin
                        s = f_emit(s, C_SPACE);
                    end
                    s = f_idle(s, r_in_byte);
                end
            end
            PH_RUN_EF: begin
                if (r_in_byte == C_VS_MID) begin
                    s.held[1] = r_in_byte;
                    s.phase = PH_RUN_EF_B8;
                end else begin
                    s = f_emit(s, C_SPACE);
                    s = f_fail(s, 2'd1, r_in_byte);
                end
            end
            PH_RUN_EF_B8: begin
                if (r_in_byte == C_VS_TEXT || r_in_byte == C_VS_EMOJI) begin
                    s = f_held(s, 2'd2);
                    s = f_emit(s, r_in_byte);
                    s.phase = PH_RUN;
                end else begin
                    s = f_emit(s, C_SPACE);
                    s = f_fail(s, 2'd2, r_in_byte);
                end
            end
            default: begin
                s = f_idle(s, r_in_byte);
            end
        endcase
        if (r_in_last) begin
            s = f_flush(s);
        end
    end

    assign o_load      = proc && (s.cnt != 3'd0);
    assign o_res.bytes = s.bytes;
    assign o_res.cnt   = s.cnt;
    assign o_res.last  = r_in_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= PH_IDLE;
            r_wrote    <= 1'b0;
            r_space    <= 1'b0;
        end else begin
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            if (proc) begin
                r_phase <= s.phase;
                r_wrote <= s.wrote;
                r_space <= s.space;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_byte <= i_byte;
            r_in_last <= i_last;
        end
        if (proc) begin
            r_held <= s.held;
        end
    end

endmodule

### design/esp_out.sv
// ----------------------------------------------------------------------------
// esp_out
// Result register: holds the bytes of one request and hands them out in order.
// ----------------------------------------------------------------------------
module esp_out
    import esp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_res       i_res,
    output logic       o_free,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_byte,
    output logic       o_last
);

    logic [MAX_OUT-1:0][7:0] r_buf;
    logic [2:0]              r_left;
    logic                    r_last;
    logic                    pop;

    assign o_valid = (r_left != 3'd0);
    assign pop     = o_valid && !i_stall;
    assign o_free  = (r_left == 3'd0) || ((r_left == 3'd1) && pop);
    assign o_byte  = r_buf[0];
    assign o_last  = r_last && (r_left == 3'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 3'd0;
        end else if (i_load) begin
            r_left <= i_res.cnt;
        end else if (pop) begin
            r_left <= r_left - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf  <= i_res.bytes;
            r_last <= i_res.last;
        end else if (pop) begin
            r_buf  <= {8'h00, r_buf[MAX_OUT-1:1]};
        end
    end

endmodule

### design/emoji_space_padder_top.sv
// ----------------------------------------------------------------------------
// emoji_space_padder_top
// Byte-serial UTF-8 filter that pads emoji and symbol runs with spaces.
// ----------------------------------------------------------------------------
// One request is taken per cycle into the input register while o_stall is
// low; it is rewritten in a single combinational pass once the result
// register is free, and its zero to five result bytes land in the result
// register, which drains one byte per cycle while i_stall is low. A request
// holds the result register until its bytes are out (one for plain text, up
// to five around a run or at end of text); a request with no bytes loads nothing.
// ----------------------------------------------------------------------------
module emoji_space_padder_top
    import esp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_out_last
);

    logic free;
    logic load;
    t_res res;

    esp_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_byte  (i_in_byte),
        .i_last  (i_in_last),
        .o_stall (o_stall),
        .i_free  (free),
        .o_load  (load),
        .o_res   (res)
    );

    esp_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_res   (res),
        .o_free  (free),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_byte  (o_out_byte),
        .o_last  (o_out_last)
    );

    a_load_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> (res.cnt != 3'd0) && (res.cnt <= 3'(MAX_OUT)))
        else $error("result count out of range");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> free)
        else $error("result register overwritten");

    a_stall_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no pending output");

    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_last |-> o_valid)
        else $error("last flag without valid output");

endmodule

### bench/emoji_space_padder_top_tb.sv
// ----------------------------------------------------------------------------
// emoji_space_padder_top_tb
// Self-checking bench for the emoji space padder. Directed texts hit emoji,
// symbols, selectors, broken prefixes and end-of-text flushes; random texts
// built from well-formed and broken tokens follow. A scoreboard predicts the
// padded byte stream and checks every result under random idles and stalls.
// ----------------------------------------------------------------------------
module emoji_space_padder_top_tb;
    import esp_pkg::*;

    localparam int WATCHDOG_LIMIT = 300;
    localparam int RANDOM_REQS    = 90;
    localparam int DRAIN_CYCLES   = 8;

    class padder_scoreboard;
        typedef struct {
            logic [7:0] b;
            logic       l;
        } out_t;

        t_phase     phase;
        logic [7:0] held [3];
        bit         wrote_any;
        bit         last_space;
        out_t       burst [$];
        out_t       padded_q [$];
        int         errors;
        int         checked;

        function new();
            phase      = PH_IDLE;
            wrote_any  = 1'b0;
            last_space = 1'b0;
            errors     = 0;
            checked    = 0;
        endfunction

        function int pending();
            return padded_q.size();
        endfunction

        function bit is_cont(logic [7:0] b);
            return (b & C_CONT_MASK) == C_CONT;
        endfunction

        function void put(logic [7:0] b);
            out_t o;
            o.b = b;
            o.l = 1'b0;
            burst.insert(burst.size(), o);
            wrote_any  = 1'b1;
            last_space = (b == C_SPACE);
        endfunction

        function void put_held(int n);
            for (int i = 0; i < n; i++) put(held[i]);
        endfunction

        function void pad_before();
            if (wrote_any && !last_space) put(C_SPACE);
        endfunction

        function void scan_fresh(logic [7:0] b);
            if (b == C_LEAD4) begin
                held[0] = b;
                phase   = PH_F0;
            end else if (b == C_LEAD3) begin
                held[0] = b;
                phase   = PH_E2;
            end else begin
                phase = PH_IDLE;
                put(b);
            end
        endfunction

        function void abandon(int n, logic [7:0] b);
            phase = PH_IDLE;
            put_held(n);
            scan_fresh(b);
        endfunction

        function void note_request(logic [7:0] b, logic l);
            burst.delete();
            case (phase)
                PH_F0: begin
                    if (b == C_PLANE) begin
                        held[1] = b;
                        phase   = PH_F0_9F;
                    end else abandon(1, b);
                end
                PH_F0_9F: begin
                    if (is_cont(b)) begin
                        held[2] = b;
                        phase   = PH_F0_9F_C;
                    end else abandon(2, b);
                end
                PH_F0_9F_C: begin
                    if (is_cont(b)) begin
                        pad_before();
                        put_held(3);
                        put(b);
                        phase = PH_RUN;
                    end else abandon(3, b);
                end
                PH_E2: begin
                    if (b >= C_SYM_LO && b <= C_SYM_HI) begin
                        held[1] = b;
                        phase   = PH_E2_X;
                    end else abandon(1, b);
                end
                PH_E2_X: begin
                    if (is_cont(b)) begin
                        pad_before();
                        put_held(2);
                        put(b);
                        phase = PH_RUN;
                    end else abandon(2, b);
                end
                PH_RUN: begin
                    if (b == C_VS_LEAD) begin
                        held[0] = b;
                        phase   = PH_RUN_EF;
                    end else begin
                        if (b != C_SPACE) put(C_SPACE);
                        scan_fresh(b);
                    end
                end
                PH_RUN_EF: begin
                    if (b == C_VS_MID) begin
                        held[1] = b;
                        phase   = PH_RUN_EF_B8;
                    end else begin
                        put(C_SPACE);
                        abandon(1, b);
                    end
                end
                PH_RUN_EF_B8: begin
                    if (b == C_VS_TEXT || b == C_VS_EMOJI) begin
                        put_held(2);
                        put(b);
                        phase = PH_RUN;
                    end else begin
                        put(C_SPACE);
                        abandon(2, b);
                    end
                end
                default: scan_fresh(b);
            endcase
            if (l) begin
                case (phase)
                    PH_F0, PH_E2:         put_held(1);
                    PH_F0_9F, PH_E2_X:    put_held(2);
                    PH_F0_9F_C:           put_held(3);
                    PH_RUN_EF: begin
                        put(C_SPACE);
                        put_held(1);
                    end
                    PH_RUN_EF_B8: begin
                        put(C_SPACE);
                        put_held(2);
                    end
                    default: ;
                endcase
                phase      = PH_IDLE;
                wrote_any  = 1'b0;
                last_space = 1'b0;
                if (burst.size() != 0) begin
                    burst[burst.size() - 1].l = 1'b1;
                end
            end
            foreach (burst[i]) padded_q.insert(padded_q.size(), burst[i]);
        endfunction

        function void check_result(logic [7:0] b, logic l);
            out_t o;
            checked++;
            if (padded_q.size() == 0) begin
                $error("unexpected result: out_byte %h out_last %b", b, l);
                errors++;
                return;
            end
            o = padded_q.pop_front();
            if (b !== o.b) begin
                $error("out_byte mismatch: expected %h, actual %h", o.b, b);
                errors++;
            end
            if (l !== o.l) begin
                $error("out_last mismatch: expected %b, actual %b", o.l, l);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_in_byte;
    logic       i_in_last;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_out_byte;
    logic       o_out_last;

    padder_scoreboard sb;
    logic [8:0]       stim_q [$];
    bit               no_idle;
    int               stall_left;
    int               idle_cycles;
    int               sent;
    int               texts;

    emoji_space_padder_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_in_byte  (i_in_byte),
        .i_in_last  (i_in_last),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_byte (o_out_byte),
        .o_out_last (o_out_last)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    task automatic add(logic [7:0] b, logic l);
        stim_q.insert(stim_q.size(), {l, b});
    endtask

    function automatic logic [7:0] cont_byte();
        return C_CONT | 8'($urandom_range(0, 63));
    endfunction

    task automatic add_token();
        int kind;
        int cut;
        kind = $urandom_range(0, 99);
        if (kind < 25) begin
            add(8'($urandom_range(1, 255)), 1'b0);
        end else if (kind < 35) begin
            add(C_SPACE, 1'b0);
        end else if (kind < 55) begin
            add(C_LEAD4, 1'b0); add(C_PLANE, 1'b0);
            add(cont_byte(), 1'b0); add(cont_byte(), 1'b0);
        end else if (kind < 70) begin
            add(C_LEAD3, 1'b0);
            add(C_SYM_LO + 8'($urandom_range(0, 6)), 1'b0);
            add(cont_byte(), 1'b0);
        end else if (kind < 82) begin
            add(C_VS_LEAD, 1'b0); add(C_VS_MID, 1'b0);
            add($urandom_range(0, 1) ? C_VS_EMOJI : C_VS_TEXT, 1'b0);
        end else begin
            // truncated prefix, usually followed by an arbitrary byte
            cut = $urandom_range(0, 6);
            case (cut)
                0: add(C_LEAD4, 1'b0);
                1: begin add(C_LEAD4, 1'b0); add(C_PLANE, 1'b0); end
                2: begin add(C_LEAD4, 1'b0); add(C_PLANE, 1'b0); add(cont_byte(), 1'b0); end
                3: add(C_LEAD3, 1'b0);
                4: begin add(C_LEAD3, 1'b0); add(C_SYM_HI, 1'b0); end
                5: add(C_VS_LEAD, 1'b0);
                default: begin add(C_VS_LEAD, 1'b0); add(C_VS_MID, 1'b0); end
            endcase
            if ($urandom_range(0, 3) != 0) add(8'($urandom_range(1, 255)), 1'b0);
        end
    endtask

    task automatic build_stimulus();
        int n;
        // directed texts
        add(8'h41, 1'b0);
        add(C_LEAD4, 1'b0); add(C_PLANE, 1'b0); add(8'h98, 1'b0); add(8'h80, 1'b0);
        add(C_VS_LEAD, 1'b0); add(C_VS_MID, 1'b0); add(C_VS_EMOJI, 1'b0);
        add(C_SPACE, 1'b0);
        add(C_LEAD3, 1'b0); add(C_SYM_HI, 1'b0); add(8'hBF, 1'b0);
        add(C_VS_LEAD, 1'b0); add(8'h41, 1'b0);
        add(C_LEAD4, 1'b0); add(C_PLANE, 1'b0); add(8'h41, 1'b1);
        add(C_LEAD3, 1'b0); add(C_SYM_LO, 1'b0); add(8'h80, 1'b0);
        add(C_VS_LEAD, 1'b0); add(C_VS_MID, 1'b1);
        add(C_LEAD4, 1'b0); add(C_PLANE, 1'b0); add(8'hFF, 1'b1);
        // random texts
        while (stim_q.size() < 25 + RANDOM_REQS) begin
            n = $urandom_range(1, 8);
            repeat (n) add_token();
            stim_q[stim_q.size() - 1][8] = 1'b1;
        end
    endtask

    task automatic send_request(logic [8:0] entry);
        i_valid   <= 1'b1;
        i_in_byte <= entry[7:0];
        i_in_last <= entry[8];
        do @(posedge i_clk); while (o_stall !== 1'b0);
        sb.note_request(entry[7:0], entry[8]);
        sent++;
        if (entry[8]) texts++;
    endtask

    // result side: check and random stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid === 1'b1 && i_stall === 1'b0) sb.check_result(o_out_byte, o_out_last);
            if (stall_left != 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (!no_idle && $urandom_range(0, 99) < 4) begin
                stall_left = $urandom_range(0, 1);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles = 0;
        end else begin
            if ((i_valid === 1'b1 && o_stall === 1'b0) ||
                (o_valid === 1'b1 && i_stall === 1'b0))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("emoji_space_padder_top regression: fail");
                $finish;
            end
        end
    end

    initial begin
        logic [8:0] entry;
        sb        = new();
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_in_byte <= 8'h41;
        i_in_last <= 1'b0;
        i_stall   <= 1'b0;
        no_idle   = 1'b0;
        sent      = 0;
        texts     = 0;
        build_stimulus();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (stim_q.size() != 0) begin
            entry   = stim_q.pop_front();
            no_idle = (sent >= 60 && sent < 100);
            if (!no_idle && $urandom_range(0, 99) < 4) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 2)) @(posedge i_clk);
            end
            send_request(entry);
        end
        i_valid <= 1'b0;
        no_idle = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d requests over %0d texts; %0d result bytes checked.",
                 sent, texts, sb.checked);
        $display("Directed emoji, symbol, selector, broken-prefix and flush cases included.");
        if (sb.errors == 0)
            $display("emoji_space_padder_top regression: pass");
        else
            $display("emoji_space_padder_top regression: fail");
        $finish;
    end

endmodule

### emoji_space_padder_top.f
design/esp_pkg.sv
design/esp_scan.sv
design/esp_out.sv
design/emoji_space_padder_top.sv
bench/emoji_space_padder_top_tb.sv
